[design/lzwc_pkg.sv]
// Shared types and constants for the LZW byte compressor.
// Used by lzwc_dict, lzwc_out_fifo and lzw_byte_compressor; depends on nothing.
package lzwc_pkg;

    // Default dictionary size in codes.
    localparam int DEF_DICT_CODES = 4096;
    // First code handed out to a new dictionary entry.
    localparam int FIRST_FREE = 257;
    // Width of the emitted codeword.
    localparam int CODE_W = 12;
    // Depth of the result queue.
    localparam int OUT_DEPTH = 4;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_CHECK
    } t_state;

    // One emitted result.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_result;

    // Dictionary memory controls for one cycle.
    typedef struct packed {
        logic slot_rd;
        logic rev_rd;
        logic wr;
    } t_dict_ctl;

endpackage

[design/lzw_byte_compressor.sv]
// LZW byte compressor with fixed 12-bit codewords: top level with the control sequencer.
// Depends on lzwc_pkg, lzwc_dict and lzwc_out_fifo.
//
// Usage: bytes enter on the input channel (i_in_valid / o_in_ready) with i_last_byte
// marking the end of a message; codewords leave on the output channel
// (o_out_valid / i_out_ready) with o_last_code on the final codeword of a message.
// Each message is compressed on its own; codes 1..256 are single bytes.
// Processing: one byte at a time; the input is not ready again until a byte is resolved.
// The first byte of a message is taken directly. Every other byte reads its hash slot
// from the slot table and, when that slot holds a code in use in this message, reads
// the reverse table to confirm it; each further probe is again a slot-table read,
// followed when needed by a reverse-table read. A codeword enters the result queue in
// the cycle in which its byte is resolved; a miss on the final byte writes two at once.
// Reset: the current string is emptied and code numbering restarts at 257. Then the
// slot table, of twice DICT_CODES rounded up to a power of two entries (8192 with the
// default size), is cleared one entry per cycle while the input is held off. Afterwards a
// slot counts only when the reverse table confirms it was written during the current
// message, so nothing is cleared between messages.
// Stalls: results collect in a four-entry queue; the input keeps taking bytes while two
// entries are free, so a stalled receiver holds off the input once fewer than two are free.
module lzw_byte_compressor import lzwc_pkg::*; #(
    parameter int DICT_CODES = DEF_DICT_CODES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_code,
    output logic        o_last_code
);

    localparam int CW = $clog2(DICT_CODES);
    localparam int HW = CW + 1;
    localparam int KW = CW + 8;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_prefix;
    logic [CW-1:0] n_prefix;
    logic [CW:0]   r_nfc;
    logic [CW:0]   n_nfc;
    logic [HW-1:0] r_clr;
    logic [HW-1:0] n_clr;
    logic [7:0]    r_byte;
    logic [7:0]    n_byte;
    logic          r_last;
    logic          n_last;
    logic [HW-1:0] r_h;
    logic [HW-1:0] n_h;

    t_dict_ctl     dict_ctl;
    logic [KW-1:0] in_key;
    logic [HW-1:0] in_hash;
    logic [HW-1:0] slot_addr;
    logic [CW-1:0] rev_addr;
    logic [KW-1:0] wr_key;
    logic [CW-1:0] wr_code;
    logic [KW-1:0] slot_key;
    logic [CW-1:0] slot_code;
    logic [HW-1:0] rev_slot;

    logic          push0;
    logic          push1;
    t_result       data0;
    t_result       data1;
    t_result       out_data;
    logic          room2;

    logic          acc;
    logic          in_range;
    logic          rev_match;
    logic          key_match;
    logic          ev_hit;
    logic          ev_miss;
    logic          ev_probe;
    logic [CW-1:0] byte_code;
    logic [CW-1:0] in_byte_code;

    // Low bits of a code as an emitted codeword.
    function automatic logic [CODE_W-1:0] to_code(input logic [CW-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[CODE_W-1:0];
    endfunction

    assign acc          = i_in_valid && o_in_ready;
    assign o_in_ready   = (r_state == S_IDLE) && room2;
    assign in_key       = {r_prefix, i_in_byte};
    assign in_byte_code = CW'(i_in_byte) + CW'(1);
    assign byte_code    = CW'(r_byte) + CW'(1);

    // A slot is live only if its code belongs to this message and the reverse table agrees.
    assign in_range  = (slot_code >= CW'(FIRST_FREE)) && ({1'b0, slot_code} < r_nfc);
    assign rev_match = (rev_slot == r_h);
    assign key_match = (slot_key == {r_prefix, r_byte});

    assign ev_hit   = (r_state == S_CHECK) && rev_match && key_match;
    assign ev_probe = (r_state == S_CHECK) && rev_match && !key_match;
    assign ev_miss  = ((r_state == S_LOOK) && !in_range) || ((r_state == S_CHECK) && !rev_match);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc && (r_prefix != '0)) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = in_range ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                n_state = ev_probe ? S_LOOK : S_IDLE;
            end
        endcase
    end

    // Datapath control, memory accesses and emitted results.
    always_comb begin
        n_prefix  = r_prefix;
        n_nfc     = r_nfc;
        n_clr     = r_clr;
        n_byte    = r_byte;
        n_last    = r_last;
        n_h       = r_h;
        dict_ctl  = '0;
        slot_addr = r_h;
        rev_addr  = slot_code;
        wr_key    = {r_prefix, r_byte};
        wr_code   = r_nfc[CW-1:0];
        push0     = 1'b0;
        push1     = 1'b0;
        data0     = '{code: to_code(r_prefix), last: 1'b0};
        data1     = '{code: to_code(byte_code), last: 1'b1};

        if (r_state == S_CLEAR) begin
            // Zero one slot per cycle so that unwritten slots read as empty.
            dict_ctl.wr = 1'b1;
            slot_addr   = r_clr;
            rev_addr    = r_clr[CW-1:0];
            wr_key      = '0;
            wr_code     = '0;
            n_clr       = r_clr + HW'(1);
        end

        if (acc) begin
            n_byte = i_in_byte;
            n_last = i_last_byte;
            if (r_prefix == '0) begin
                // First byte of a message starts the string directly.
                n_prefix = in_byte_code;
                if (i_last_byte) begin
                    push0    = 1'b1;
                    data0    = '{code: to_code(in_byte_code), last: 1'b1};
                    n_prefix = '0;
                    n_nfc    = (CW+1)'(FIRST_FREE);
                end
            end else begin
                // Start the lookup at the hashed slot.
                dict_ctl.slot_rd = 1'b1;
                slot_addr        = in_hash;
                n_h              = in_hash;
            end
        end

        if ((r_state == S_LOOK) && in_range) begin
            // Confirm the slot's owner in the reverse table.
            dict_ctl.rev_rd = 1'b1;
            rev_addr        = slot_code;
        end

        if (ev_probe) begin
            // Occupied by another string: try the next slot.
            dict_ctl.slot_rd = 1'b1;
            slot_addr        = r_h + HW'(1);
            n_h              = r_h + HW'(1);
        end

        if (ev_hit) begin
            n_prefix = slot_code;
            if (r_last) begin
                push0    = 1'b1;
                data0    = '{code: to_code(slot_code), last: 1'b1};
                n_prefix = '0;
                n_nfc    = (CW+1)'(FIRST_FREE);
            end
        end

        if (ev_miss) begin
            // Emit the prefix, insert the new string while there is room, restart from the byte.
            push0    = 1'b1;
            data0    = '{code: to_code(r_prefix), last: 1'b0};
            n_prefix = byte_code;
            if (r_nfc < (CW+1)'(DICT_CODES)) begin
                dict_ctl.wr = 1'b1;
                slot_addr   = r_h;
                rev_addr    = r_nfc[CW-1:0];
                n_nfc       = r_nfc + (CW+1)'(1);
            end
            if (r_last) begin
                push1    = 1'b1;
                data1    = '{code: to_code(byte_code), last: 1'b1};
                n_prefix = '0;
                n_nfc    = (CW+1)'(FIRST_FREE);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_prefix <= '0;
            r_nfc    <= (CW+1)'(FIRST_FREE);
            r_clr    <= '0;
        end else begin
            r_state  <= n_state;
            r_prefix <= n_prefix;
            r_nfc    <= n_nfc;
            r_clr    <= n_clr;
        end
    end

    // Item payload registers.
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_h    <= n_h;
    end

    lzwc_dict #(
        .DICT_CODES (DICT_CODES)
    ) u_dict (
        .i_clk       (i_clk),
        .i_ctl       (dict_ctl),
        .i_key       (in_key),
        .o_hash      (in_hash),
        .i_slot_addr (slot_addr),
        .i_rev_addr  (rev_addr),
        .i_wr_key    (wr_key),
        .i_wr_code   (wr_code),
        .o_slot_key  (slot_key),
        .o_slot_code (slot_code),
        .o_rev_slot  (rev_slot)
    );

    lzwc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_data0 (data0),
        .i_push1 (push1),
        .i_data1 (data1),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_code      = out_data.code;
    assign o_last_code = out_data.last;

endmodule

[design/lzwc_dict.sv]
// Dictionary storage: a hash table of (key, code) slots and a reverse table code -> slot.
// Depends on lzwc_pkg for the control struct.
module lzwc_dict import lzwc_pkg::*; #(
    parameter int DICT_CODES = DEF_DICT_CODES
) (
    input  logic                           i_clk,
    input  t_dict_ctl                      i_ctl,
    input  logic [$clog2(DICT_CODES)+7:0]  i_key,
    output logic [$clog2(DICT_CODES):0]    o_hash,
    input  logic [$clog2(DICT_CODES):0]    i_slot_addr,
    input  logic [$clog2(DICT_CODES)-1:0]  i_rev_addr,
    input  logic [$clog2(DICT_CODES)+7:0]  i_wr_key,
    input  logic [$clog2(DICT_CODES)-1:0]  i_wr_code,
    output logic [$clog2(DICT_CODES)+7:0]  o_slot_key,
    output logic [$clog2(DICT_CODES)-1:0]  o_slot_code,
    output logic [$clog2(DICT_CODES):0]    o_rev_slot
);

    localparam int CW = $clog2(DICT_CODES);
    localparam int HW = CW + 1;
    localparam int KW = CW + 8;
    localparam int SLOTS = 1 << HW;
    localparam int CODES = 1 << CW;

    logic [KW+CW-1:0] r_slot_mem [SLOTS];
    logic [HW-1:0]    r_rev_mem  [CODES];
    logic [KW+CW-1:0] r_slot_q;
    logic [HW-1:0]    r_rev_q;

    // The prefix lands shifted by one and the byte in the top bits of the slot index.
    function automatic logic [HW-1:0] hash_key(input logic [KW-1:0] key);
        return {key[KW-1:8], 1'b0} ^ {key[7:0], {(HW-8){1'b0}}};
    endfunction

    assign o_hash = hash_key(i_key);

    // Slot table: written on insert and during the reset clear, read one slot per probe.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_slot_mem[i_slot_addr] <= {i_wr_key, i_wr_code};
        end
        if (i_ctl.slot_rd) begin
            r_slot_q <= r_slot_mem[i_slot_addr];
        end
    end

    // Reverse table: records which slot holds each code of the current message.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_rev_mem[i_rev_addr] <= i_slot_addr;
        end
        if (i_ctl.rev_rd) begin
            r_rev_q <= r_rev_mem[i_rev_addr];
        end
    end

    assign o_slot_key  = r_slot_q[KW+CW-1:CW];
    assign o_slot_code = r_slot_q[CW-1:0];
    assign o_rev_slot  = r_rev_q;

endmodule

[design/lzwc_out_fifo.sv]
// Small result queue that takes up to two results per cycle and hands out one.
// Depends on lzwc_pkg for the result type and depth.
module lzwc_out_fifo import lzwc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push0,
    input  t_result i_data0,
    input  logic    i_push1,
    input  t_result i_data1,
    output logic    o_room2,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    localparam int PW = $clog2(OUT_DEPTH);
    localparam int NW = PW + 1;

    t_result       r_mem [OUT_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_cnt;
    logic [PW-1:0] wp1;
    logic          pop;
    logic [NW-1:0] n_push;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_room2 = (r_cnt <= NW'(OUT_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign wp1     = r_wp + PW'(1);
    assign n_push  = NW'(i_push0) + NW'(i_push1);

    // Entry storage; the second result goes right after the first.
    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wp] <= i_data0;
        end
        if (i_push1) begin
            r_mem[wp1] <= i_data1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(n_push);
            r_rp  <= r_rp + PW'(pop);
            r_cnt <= r_cnt + n_push - NW'(pop);
        end
    end

endmodule
